### rtl/b64d_pkg.sv
package b64d_pkg;

  // Character codes that need special handling
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_UNDER = 8'h5F;

  // Alphabet offsets
  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;

  // Sextet lookup result: bit 6 flags a character outside the alphabet
  typedef struct packed {
    logic       invalid;
    logic [5:0] value;
  } sextet_t;

  // One group of up to three result items, handed from decode to output stage
  typedef struct packed {
    logic [1:0]      count;      // number of items in the group (1..3)
    logic [2:0][7:0] bytes;      // item 0 in bytes[0]
    logic            byte_valid; // 0 only for an empty end-of-message item
    logic            done;       // final item of the group ends the message
  } group_t;

  // Map one character to its 6-bit value, after the optional URL remap
  function automatic sextet_t sextet_of(input logic [7:0] c_in, input logic url);
    logic [7:0] c;
    logic [7:0] v;
    sextet_t    r;
    c = c_in;
    if (url && (c_in == CHAR_DASH))  c = CHAR_PLUS;
    if (url && (c_in == CHAR_UNDER)) c = CHAR_SLASH;
    r.invalid = 1'b0;
    v         = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: v = c - 8'h41;
      [8'h61:8'h7A]: v = c - 8'h61 + LOWER_BASE;
      [8'h30:8'h39]: v = c - 8'h30 + DIGIT_BASE;
      CHAR_PLUS:     v = 8'd62;
      CHAR_SLASH:    v = 8'd63;
      default:       r.invalid = 1'b1;
    endcase
    r.value = v[5:0];
    return r;
  endfunction

endpackage

### rtl/b64d_core.sv
module b64d_core import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       url_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       grp_valid_o,
  input  logic       grp_ready_i,
  output group_t     grp_o
);

  logic        in_vld_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic [17:0] buf_q, buf_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stop_q, stop_d;
  logic        adv;

  sextet_t     sx;
  logic [17:0] buf_n;
  logic [1:0]  cnt_n;
  logic        stop_n;
  logic        flush_en;
  logic [17:0] fl_buf;
  logic [1:0]  fl_cnt;
  logic [17:0] al;
  logic [7:0]  fb0, fb1;
  group_t      g;

  // Step through the character against the buffered group
  always_comb begin
    sx     = sextet_of(char_q, url_i);
    buf_n  = buf_q;
    cnt_n  = cnt_q;
    stop_n = stop_q;
    g      = '0;
    if (!stop_q) begin
      if (sx.invalid) begin
        stop_n = 1'b1;
      end else if (cnt_q == 2'd3) begin
        // full quartet: three bytes out
        g.count    = 2'd3;
        g.bytes[0] = {buf_q[17:12], buf_q[11:10]};
        g.bytes[1] = {buf_q[9:6], buf_q[5:2]};
        g.bytes[2] = {buf_q[1:0], sx.value};
        buf_n      = '0;
        cnt_n      = 2'd0;
      end else begin
        buf_n = {buf_q[11:0], sx.value};
        cnt_n = cnt_q + 2'd1;
      end
    end

    // flush on a foreign character, or at message end while still decoding
    flush_en = (!stop_q && sx.invalid) || (last_q && !stop_n);
    fl_buf   = (!stop_q && sx.invalid) ? buf_q : buf_n;
    fl_cnt   = (!stop_q && sx.invalid) ? cnt_q : cnt_n;
    case (fl_cnt)
      2'd1:    al = {fl_buf[5:0], 12'd0};
      2'd2:    al = {fl_buf[11:0], 6'd0};
      2'd3:    al = fl_buf;
      default: al = '0;
    endcase
    fb0 = {al[17:12], al[11:10]};
    fb1 = {al[9:6], al[5:2]};
    if (flush_en && (fl_cnt >= 2'd2)) begin
      g.bytes[0] = fb0;
      g.bytes[1] = (fl_cnt == 2'd3) ? fb1 : 8'd0;
      g.count    = (fl_cnt == 2'd3) ? 2'd2 : 2'd1;
    end
    if (flush_en) begin
      buf_n = '0;
      cnt_n = 2'd0;
    end

    g.byte_valid = 1'b1;
    g.done       = last_q;
    // message end with nothing decoded still gives one marker item
    if (last_q && (g.count == 2'd0)) begin
      g.count      = 2'd1;
      g.byte_valid = 1'b0;
    end
  end

  assign adv         = in_vld_q && ((g.count == 2'd0) || grp_ready_i);
  assign in_ready_o  = !in_vld_q || adv;
  assign grp_valid_o = in_vld_q && (g.count != 2'd0);
  assign grp_o       = g;

  // Decoder state after the item is consumed
  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    if (adv) begin
      if (last_q) begin
        buf_d  = '0;
        cnt_d  = 2'd0;
        stop_d = 1'b0;
      end else begin
        buf_d  = buf_n;
        cnt_d  = cnt_n;
        stop_d = stop_n;
      end
    end
  end

  // Input register and decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      buf_q    <= '0;
      cnt_q    <= 2'd0;
      stop_q   <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= in_char_i;
      last_q <= in_last_i;
    end
  end

endmodule

### rtl/b64d_emit.sv
module b64d_emit import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grp_valid_i,
  output logic       grp_ready_o,
  input  group_t     grp_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_byte_valid_o,
  output logic       out_run_last_o,
  output logic       out_done_o
);

  logic       vld_q;
  group_t     grp_q;
  logic [1:0] idx_q, idx_d;
  logic       is_last;
  logic       take;
  logic       load;

  // Serialise the held group, one item per cycle while the receiver is ready
  assign is_last     = (idx_q == (grp_q.count - 2'd1));
  assign take        = vld_q && out_ready_i;
  assign grp_ready_o = !vld_q || (take && is_last);
  assign load        = grp_valid_i && grp_ready_o;

  assign out_valid_o      = vld_q;
  assign out_byte_o       = grp_q.bytes[idx_q];
  assign out_byte_valid_o = grp_q.byte_valid;
  assign out_run_last_o   = is_last;
  assign out_done_o       = is_last && grp_q.done;

  always_comb begin
    idx_d = idx_q;
    if (load)      idx_d = 2'd0;
    else if (take) idx_d = idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else begin
      if (grp_ready_o) vld_q <= grp_valid_i;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) grp_q <= grp_i;
  end

endmodule

### rtl/base64_stream_decoder_top.sv
// Streaming base64 decoder (standard or URL alphabet).
// Slave side: one character per item on s_axis_tdata_i, s_axis_tlast_i marks the
// message's final character. Master side: one decoded byte per item; tuser
// carries a byte-valid flag and a flag for the last item caused by one
// character; tlast marks the final item of the message. A message end with no
// decoded byte still gives one item with the byte-valid flag low.
// cfg_wr_en_i / cfg_wr_data_i set the URL alphabet (1) or standard (0);
// write it only while the block is idle.
// A character is held in the input register, its group in the result register.
// Throughput: one character per cycle in steady decoding with a ready receiver;
// a full quartet gives three items over its four characters. A group of two or
// three items holds the output until its last item is taken, and a character
// with a result waits meanwhile.
// Reset clears the decoder state and selects the standard alphabet.
// When the receiver stalls the result register holds; characters without a
// result still pass, and the first one with a result waits in the input
// register, with s_axis_tready_o low meanwhile; nothing is lost.
module base64_stream_decoder_top import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_wr_en_i,
  input  logic       cfg_wr_data_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] text_char
  input  logic       s_axis_tlast_i,  // message_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] data_byte
  output logic [1:0] m_axis_tuser_o,  // [0] byte_valid, [1] run_last
  output logic       m_axis_tlast_o   // message_done
);

  logic   url_q;
  logic   grp_valid;
  logic   grp_ready;
  group_t grp;

  // Alphabet select register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b0;
    end else if (cfg_wr_en_i) begin
      url_q <= cfg_wr_data_i;
    end
  end

  b64d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .url_i       (url_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_char_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  b64d_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grp_valid_i      (grp_valid),
    .grp_ready_o      (grp_ready),
    .grp_i            (grp),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_byte_o       (m_axis_tdata_o),
    .out_byte_valid_o (m_axis_tuser_o[0]),
    .out_run_last_o   (m_axis_tuser_o[1]),
    .out_done_o       (m_axis_tlast_o)
  );

endmodule

### tb/sv/tb.sv
module tb;
  import b64d_pkg::*;

  localparam logic [7:0] CHAR_PAD        = 8'h3D;
  localparam logic [6:0] NOT_IN_ALPHABET = 7'h40;
  localparam int unsigned QUIET_LIMIT    = 3000;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned LONG_HOLD      = 80;

  // one decoded item as seen on the master side
  typedef struct {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_done;
  } decoded_t;

  // Decoder predictor and store of the decoded items still to arrive
  class b64_scoreboard;
    logic        url_mode;
    logic [17:0] sextets;
    logic [1:0]  held;
    logic        halted;
    decoded_t    pending_bytes[$];
    int unsigned fails, checked, chars, messages;

    function new();
      url_mode = 1'b0;
      sextets  = '0;
      held     = '0;
      halted   = 1'b0;
      fails    = 0;
      checked  = 0;
      chars    = 0;
      messages = 0;
    endfunction

    // 6-bit value of a character, bit 6 set when it is foreign
    function logic [6:0] alphabet_value(logic [7:0] ch);
      logic [7:0] c;
      c = ch;
      if (url_mode && ch == CHAR_DASH)  c = CHAR_PLUS;
      if (url_mode && ch == CHAR_UNDER) c = CHAR_SLASH;
      if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
      if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
      if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
      if (c == CHAR_PLUS)       return 7'd62;
      if (c == CHAR_SLASH)      return 7'd63;
      return NOT_IN_ALPHABET;
    endfunction

    function decoded_t data_item(logic [7:0] b);
      decoded_t d;
      d.data_byte    = b;
      d.byte_valid   = 1'b1;
      d.run_last     = 1'b0;
      d.message_done = 1'b0;
      return d;
    endfunction

    // emit what a partial group holds, then empty it
    function void flush_partial(ref decoded_t run[$]);
      if (held == 2'd2)
        run = {run, data_item({sextets[11:6], sextets[5:4]})};
      if (held == 2'd3) begin
        run = {run, data_item({sextets[17:12], sextets[11:10]})};
        run = {run, data_item({sextets[9:6], sextets[5:2]})};
      end
      sextets = '0;
      held    = '0;
    endfunction

    // an accepted character: work out the items it releases
    function void note_char(logic [7:0] ch, logic last);
      decoded_t   run[$];
      logic [6:0] v;
      chars++;
      if (!halted) begin
        v = alphabet_value(ch);
        if (v[6]) begin
          flush_partial(run);
          halted = 1'b1;
        end else if (held == 2'd3) begin
          run = {run, data_item({sextets[17:12], sextets[11:10]})};
          run = {run, data_item({sextets[9:6], sextets[5:2]})};
          run = {run, data_item({sextets[1:0], v[5:0]})};
          sextets = '0;
          held    = '0;
        end else begin
          sextets = {sextets[11:0], v[5:0]};
          held    = held + 2'd1;
        end
      end
      if (last) begin
        if (!halted) flush_partial(run);
        // message end with nothing decoded still gives one empty item
        if (run.size() == 0) begin
          run = {run, data_item(8'h00)};
          run[0].byte_valid = 1'b0;
        end
        run[run.size()-1].message_done = 1'b1;
        sextets = '0;
        held    = '0;
        halted  = 1'b0;
        messages++;
      end
      if (run.size() != 0) run[run.size()-1].run_last = 1'b1;
      pending_bytes = {pending_bytes, run};
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch: %s got %0h want %0h (item %0d)", what, got, want, checked);
      fails++;
    endtask

    // an accepted item on the master side against the oldest prediction
    task check_byte(logic [7:0] data, logic [1:0] user, logic last);
      decoded_t want;
      if (pending_bytes.size() == 0) begin
        report("item with none predicted, data", data, 8'h00);
      end else begin
        want = pending_bytes.pop_front();
        if (data !== want.data_byte) report("data_byte", data, want.data_byte);
        if (user[0] !== want.byte_valid)
          report("byte_valid", 8'(user[0]), 8'(want.byte_valid));
        if (user[1] !== want.run_last)
          report("run_last", 8'(user[1]), 8'(want.run_last));
        if (last !== want.message_done)
          report("message_done", 8'(last), 8'(want.message_done));
      end
      checked++;
    endtask
  endclass

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       cfg_we   = 1'b0;
  logic       cfg_data = 1'b0;
  logic       s_valid  = 1'b0;
  logic [7:0] s_data   = 8'h00;
  logic       s_last   = 1'b0;
  logic       m_ready  = 1'b0;
  logic       s_ready, m_valid, m_last;
  logic [7:0] m_data;
  logic [1:0] m_user;

  b64_scoreboard sb = new();
  logic          calm = 1'b0;
  int unsigned   stall_cycles = 0;
  int unsigned   quiet = 0;

  base64_stream_decoder_top DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_wr_en_i     (cfg_we),
    .cfg_wr_data_i   (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // master-side monitor
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_byte(m_data, m_user, m_last);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("base64_stream_decoder_top regression: fail");
      $finish;
    end
  end

  // receiver: ready bursts, random stalls, one long hold on request
  initial begin
    int unsigned n;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (stall_cycles != 0) begin
        n = stall_cycles;
        stall_cycles = 0;
        m_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // offer one character, with an occasional gap first, until it is taken
  task automatic send_char(input logic [7:0] ch, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= ch;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    sb.note_char(ch, last);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  task automatic set_url(input logic mode);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.url_mode = mode;
  endtask

  // block idle: nothing predicted left, plus the pipeline depth
  task automatic drain();
    s_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol(input logic url);
    int unsigned k;
    k = $urandom_range(0, 63);
    if (k < 26) return 8'("A" + k);
    if (k < 52) return 8'("a" + k - 26);
    if (k < 62) return 8'("0" + k - 52);
    if (k == 62) return (url && $urandom_range(0, 1)) ? CHAR_DASH : CHAR_PLUS;
    return (url && $urandom_range(0, 1)) ? CHAR_UNDER : CHAR_SLASH;
  endfunction

  function automatic logic [7:0] pick_foreign(input logic url);
    case ($urandom_range(0, 3))
      0: return url ? CHAR_PAD : CHAR_DASH;
      1: return url ? CHAR_PAD : CHAR_UNDER;
      2: return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 42));
    endcase
  endfunction

  // one message: mostly well-formed, some noise and broken ones
  task automatic send_message(input logic url);
    logic [7:0]  msg[$];
    int unsigned kind, len;
    kind = $urandom_range(0, 9);
    len  = $urandom_range(1, 16);
    if (kind < 7) begin
      repeat (len) msg = {msg, pick_symbol(url)};
      if (len % 4 >= 2 && $urandom_range(0, 1)) repeat (4 - len % 4) msg = {msg, CHAR_PAD};
      if ($urandom_range(0, 5) == 0) msg = {msg, 8'($urandom_range(0, 255))};
    end else if (kind == 7) begin
      repeat ($urandom_range(1, 8)) msg = {msg, 8'($urandom_range(0, 255))};
    end else if (kind == 8) begin
      repeat (len) msg = {msg, pick_symbol(url)};
      msg[$urandom_range(0, len - 1)] = pick_foreign(url);
    end else begin
      msg = {msg, ($urandom_range(0, 1) ? pick_symbol(url) : CHAR_PAD)};
    end
    foreach (msg[k]) send_char(msg[k], k == msg.size() - 1);
  endtask

  task automatic run_messages(input logic url, input int unsigned count,
                              input logic squeeze);
    int unsigned first;
    first = sb.chars;
    while (sb.chars - first < count) begin
      if (squeeze && sb.chars - first >= count / 2) begin
        stall_cycles = LONG_HOLD;
        squeeze = 1'b0;
      end
      send_message(url);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // standard alphabet: full groups, extremes, padding, foreign characters
    set_url(1'b0);
    send_text("TWFu");
    send_text("////");
    send_text("QQ==");
    send_text("QUI=");
    send_text("Q");
    send_text("=");
    send_text("Zm-v");
    send_char("z", 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b1);
    run_messages(1'b0, 85, 1'b0);
    drain();

    // URL alphabet, with one long receiver hold
    set_url(1'b1);
    send_text("-_-_");
    send_text("_w");
    run_messages(1'b1, 85, 1'b1);
    drain();

    set_url(1'b0);
    run_messages(1'b0, 85, 1'b0);
    drain();

    // final stretch without idling on either side
    set_url(1'b1);
    calm = 1'b1;
    run_messages(1'b1, 85, 1'b0);
    drain();

    $display("decoded %0d characters in %0d messages over both alphabets", sb.chars,
             sb.messages);
    $display("%0d output items checked, %0d mismatches", sb.checked, sb.fails);
    if (sb.fails == 0 && sb.pending_bytes.size() == 0) begin
      $display("base64_stream_decoder_top regression: pass");
    end else begin
      $display("base64_stream_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

### base64_stream_decoder_top.f
rtl/b64d_pkg.sv
rtl/b64d_core.sv
rtl/b64d_emit.sv
rtl/base64_stream_decoder_top.sv
tb/sv/tb.sv
